// File: rtl/itc_pkg.sv
// shared constants, types and mode tables for the i2c timing word calculator
// no dependencies; used by every file of the block
`timescale 1ns / 1ps
`default_nettype none

package itc_pkg;

	localparam int PRESCALE_STEPS = 16;
	localparam logic [3:0] PRESC_LAST = 4'(PRESCALE_STEPS - 1);

	localparam logic [31:0] FALLBACK_WORD = 32'h10C0_ECFF;

	// serial divider geometry
	localparam int DIV_W = 46;
	localparam int DEN_W = 30;
	localparam int CNT_W = 6;
	localparam int NS_W = 13;
	localparam int TGT_W = 19;

	localparam logic [CNT_W-1:0] ITERS_32 = CNT_W'(32);
	localparam logic [CNT_W-1:0] ITERS_46 = CNT_W'(DIV_W);
	localparam logic [DIV_W-1:0] NS_ROUND_UP = DIV_W'(64'd999999999);
	localparam logic [DEN_W-1:0] NS_PER_SEC = DEN_W'(64'd1000000000);
	localparam logic [3:0] DELAY_CAP = 4'd15;
	localparam logic [15:0] MIN_COUNT = 16'd2;
	localparam logic [3:0] MUL_LAST = 4'(NS_W - 1);

	// speed codes
	localparam logic [1:0] MODE_400K = 2'd1;
	localparam logic [1:0] MODE_50K = 2'd2;

	// timing parameters per prescaler, in evaluation order
	localparam logic [1:0] PAR_LOW = 2'd0;
	localparam logic [1:0] PAR_HIGH = 2'd1;
	localparam logic [1:0] PAR_SDA = 2'd2;
	localparam logic [1:0] PAR_SCL = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F_GO,
		ST_F_WAIT,
		ST_MUL,
		ST_NS_GO,
		ST_NS_WAIT,
		ST_P_GO,
		ST_P_WAIT,
		ST_CHECK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [CNT_W-1:0] iters;
	} div_ctl_t;

	function automatic logic [TGT_W-1:0] target_of(input logic [1:0] mode);
		logic [TGT_W-1:0] t;
		case (mode)
			MODE_400K: t = TGT_W'(400000);
			MODE_50K: t = TGT_W'(50000);
			default: t = TGT_W'(100000);
		endcase
		return t;
	endfunction

	function automatic logic [NS_W-1:0] ns_of(input logic [1:0] mode, input logic [1:0] par);
		logic [NS_W-1:0] n;
		case (mode)
			MODE_400K: begin
				case (par)
					PAR_LOW: n = NS_W'(650);
					PAR_HIGH: n = NS_W'(340);
					PAR_SDA: n = NS_W'(100);
					default: n = NS_W'(200);
				endcase
			end
			MODE_50K: begin
				case (par)
					PAR_LOW: n = NS_W'(5200);
					PAR_HIGH: n = NS_W'(4300);
					PAR_SDA: n = NS_W'(350);
					default: n = NS_W'(350);
				endcase
			end
			default: begin
				case (par)
					PAR_LOW: n = NS_W'(4900);
					PAR_HIGH: n = NS_W'(4200);
					PAR_SDA: n = NS_W'(280);
					default: n = NS_W'(320);
				endcase
			end
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// File: rtl/itc_sdiv.sv
// radix-2 restoring divider, one quotient bit per cycle
// dividend is left aligned; depends on itc_pkg
`timescale 1ns / 1ps
`default_nettype none

module itc_sdiv (
	input wire logic clk,
	input wire logic arst_n,
	input wire itc_pkg::div_ctl_t ctl,
	input wire logic [itc_pkg::DIV_W-1:0] dividend,
	input wire logic [itc_pkg::DEN_W-1:0] divisor,
	output logic done,
	output logic [itc_pkg::DIV_W-1:0] quotient
);

	logic [itc_pkg::DIV_W-1:0] num_q;
	logic [itc_pkg::DEN_W-1:0] rem_q;
	logic [itc_pkg::DEN_W-1:0] den_q;
	logic [itc_pkg::CNT_W-1:0] cnt_q;
	logic [itc_pkg::CNT_W-1:0] last_q;
	logic run_q;
	logic done_q;

	logic [itc_pkg::DEN_W:0] trial;
	logic [itc_pkg::DEN_W:0] diff;
	logic ge;

	assign trial = {rem_q, num_q[itc_pkg::DIV_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == last_q) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
			last_q <= ctl.iters - 1'b1;
		end else if (run_q) begin
			num_q <= {num_q[itc_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[itc_pkg::DEN_W-1:0] : trial[itc_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

// File: rtl/i2c_timing_word_calculator_top.sv
// i2c timing word calculator: prescaler search sequencer, serial multiply
// depends on itc_pkg and itc_sdiv
// prescalers tried: 1 to 16; a zero clock goes straight to the result with no search
// per prescaler six divides (32 or 46 steps each) and four 13-bit shift-add multiplies
// plus one check state; a new request is taken only once the word is done
// busy is high from acceptance through the done strobe
// asynchronous active-low reset returns the sequencer to idle; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module i2c_timing_word_calculator_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [31:0] kernel_clock_hz,
	input wire logic [1:0] speed_mode,
	output logic done,
	output logic [31:0] timing_word,
	output logic used_fallback
);

	itc_pkg::state_t state_q, state_d;

	logic [31:0] clk_q;
	logic [1:0] mode_q;
	logic [3:0] presc_q;
	logic [1:0] par_q;
	logic [31:0] f_q;
	logic [itc_pkg::DIV_W-1:0] acc_q;
	logic [itc_pkg::NS_W-1:0] ns_q;
	logic [3:0] bit_cnt_q;
	logic [15:0] low_q;
	logic [15:0] high_q;
	logic [3:0] sda_q;
	logic [3:0] scl_q;
	logic [31:0] period_q;
	logic [31:0] word_q;
	logic fb_q;

	itc_pkg::div_ctl_t div_ctl;
	logic [itc_pkg::DIV_W-1:0] div_num;
	logic [itc_pkg::DEN_W-1:0] div_den;
	logic div_done;
	logic [itc_pkg::DIV_W-1:0] div_quo;

	logic [32:0] need;
	logic [31:0] scll;
	logic fit;
	logic [15:0] q16;

	itc_sdiv u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.dividend(div_num),
		.divisor(div_den),
		.done(div_done),
		.quotient(div_quo)
	);

	assign q16 = (div_quo[itc_pkg::DIV_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
	assign need = 33'(low_q) + 33'(high_q) + 33'd8;
	assign scll = period_q - 32'(high_q) - 32'd6;
	assign fit = ({1'b0, period_q} >= need) && (scll >= 32'(low_q)) && (scll <= 32'd255)
		&& (high_q <= 16'd255);

	always_comb begin
		state_d = state_q;
		div_ctl.start = 1'b0;
		div_ctl.iters = itc_pkg::ITERS_32;
		div_num = {clk_q, 14'b0};
		div_den = itc_pkg::DEN_W'({presc_q} + 5'd1);
		case (state_q)
			itc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (kernel_clock_hz == 32'd0) ? itc_pkg::ST_OUT : itc_pkg::ST_F_GO;
				end
			end
			itc_pkg::ST_F_GO: begin
				div_ctl.start = 1'b1;
				state_d = itc_pkg::ST_F_WAIT;
			end
			itc_pkg::ST_F_WAIT: begin
				if (div_done) state_d = itc_pkg::ST_MUL;
			end
			itc_pkg::ST_MUL: begin
				if (bit_cnt_q == itc_pkg::MUL_LAST) state_d = itc_pkg::ST_NS_GO;
			end
			itc_pkg::ST_NS_GO: begin
				div_ctl.start = 1'b1;
				div_ctl.iters = itc_pkg::ITERS_46;
				div_num = acc_q + itc_pkg::NS_ROUND_UP;
				div_den = itc_pkg::NS_PER_SEC;
				state_d = itc_pkg::ST_NS_WAIT;
			end
			itc_pkg::ST_NS_WAIT: begin
				if (div_done) begin
					state_d = (par_q == itc_pkg::PAR_SCL) ? itc_pkg::ST_P_GO : itc_pkg::ST_MUL;
				end
			end
			itc_pkg::ST_P_GO: begin
				div_ctl.start = 1'b1;
				div_num = {f_q, 14'b0};
				div_den = itc_pkg::DEN_W'(itc_pkg::target_of(mode_q));
				state_d = itc_pkg::ST_P_WAIT;
			end
			itc_pkg::ST_P_WAIT: begin
				if (div_done) state_d = itc_pkg::ST_CHECK;
			end
			itc_pkg::ST_CHECK: begin
				if (fit || presc_q == itc_pkg::PRESC_LAST) state_d = itc_pkg::ST_OUT;
				else state_d = itc_pkg::ST_F_GO;
			end
			itc_pkg::ST_OUT: begin
				state_d = itc_pkg::ST_IDLE;
			end
			default: begin
				state_d = itc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			itc_pkg::ST_IDLE: begin
				clk_q <= kernel_clock_hz;
				mode_q <= speed_mode;
				presc_q <= '0;
				word_q <= itc_pkg::FALLBACK_WORD;
				fb_q <= 1'b1;
			end
			itc_pkg::ST_F_WAIT: begin
				f_q <= div_quo[31:0];
				par_q <= itc_pkg::PAR_LOW;
				ns_q <= itc_pkg::ns_of(mode_q, itc_pkg::PAR_LOW);
				acc_q <= '0;
				bit_cnt_q <= '0;
			end
			itc_pkg::ST_MUL: begin
				acc_q <= {acc_q[itc_pkg::DIV_W-2:0], 1'b0}
					+ (ns_q[itc_pkg::NS_W-1] ? itc_pkg::DIV_W'(f_q) : '0);
				ns_q <= {ns_q[itc_pkg::NS_W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			itc_pkg::ST_NS_WAIT: begin
				if (div_done) begin
					case (par_q)
						itc_pkg::PAR_LOW: low_q <= (q16 < itc_pkg::MIN_COUNT)
							? itc_pkg::MIN_COUNT : q16;
						itc_pkg::PAR_HIGH: high_q <= (q16 < itc_pkg::MIN_COUNT)
							? itc_pkg::MIN_COUNT : q16;
						itc_pkg::PAR_SDA: sda_q <= (q16 > 16'(itc_pkg::DELAY_CAP)) ? itc_pkg::DELAY_CAP
							: q16[3:0];
						default: scl_q <= (q16 > 16'(itc_pkg::DELAY_CAP)) ? itc_pkg::DELAY_CAP
							: q16[3:0];
					endcase
					par_q <= par_q + 1'b1;
					ns_q <= itc_pkg::ns_of(mode_q, par_q + 1'b1);
					acc_q <= '0;
					bit_cnt_q <= '0;
				end
			end
			itc_pkg::ST_P_WAIT: begin
				period_q <= div_quo[31:0];
			end
			itc_pkg::ST_CHECK: begin
				if (fit) begin
					word_q <= {presc_q, 4'b0, scl_q, sda_q, high_q[7:0], scll[7:0]};
					fb_q <= 1'b0;
				end
				presc_q <= presc_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != itc_pkg::ST_IDLE;
	assign done = state_q == itc_pkg::ST_OUT;
	assign timing_word = word_q;
	assign used_fallback = fb_q;

endmodule

`default_nettype wire

// File: rtl/itc_checker.sv
// port-level checks for the i2c timing word calculator, bound to the top level
// depends on itc_pkg
`timescale 1ns / 1ps
`default_nettype none

module itc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [31:0] timing_word,
	input wire logic used_fallback
);

	// result strobe only while a word is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		done && used_fallback |-> timing_word == itc_pkg::FALLBACK_WORD)
		else $error("fallback word mismatch");

	// fitted word has reserved bits clear and counts at least two
	a_fit_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && !used_fallback |-> timing_word[27:24] == 4'd0 && timing_word[7:0] >= 8'd2
			&& timing_word[15:8] >= 8'd2)
		else $error("fitted word malformed");

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done not single or block not idle after");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

endmodule

bind i2c_timing_word_calculator_top itc_checker u_itc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.timing_word(timing_word),
	.used_fallback(used_fallback)
);

`default_nettype wire

// File: verif/itc_word_checker.sv
// i2c timing word checker: predicts each word from the accepted request and compares
// it with the done strobe; depends on itc_pkg and is instantiated by the testbench top
`timescale 1ns / 1ps

module itc_word_checker
	import itc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [31:0] kernel_clock_hz,
	input wire logic [1:0] speed_mode,
	input wire logic done,
	input wire logic [31:0] timing_word,
	input wire logic used_fallback,
	output int error_count,
	output int words_in_flight
);

	localparam longint unsigned CEIL_BIAS = 64'd999_999_999;
	localparam longint unsigned NS_IN_SEC = 64'd1_000_000_000;
	localparam longint unsigned COUNT_MAX = 64'd255;

	typedef struct packed {
		logic [31:0] hz;
		logic [1:0] mode;
		logic [31:0] word;
		logic fallback;
	} timing_result_t;

	timing_result_t expected_words[$];

	function automatic longint unsigned ns_to_ticks(input longint unsigned ns,
			input longint unsigned f);
		return ((ns * f + CEIL_BIAS) / NS_IN_SEC) & 64'hFFFF_FFFF;
	endfunction

	function automatic timing_result_t predict_timing_word(input logic [31:0] hz,
			input logic [1:0] mode);
		timing_result_t r;
		longint unsigned bus_hz, t_low_ns, t_high_ns, t_sda_ns, t_scl_ns;
		longint unsigned f, low_min, high_min, sdadel, scldel, period, scll;
		int unsigned p;
		bit found;
		r.hz = hz;
		r.mode = mode;
		r.word = FALLBACK_WORD;
		r.fallback = 1'b1;
		found = 1'b0;
		case (mode)
			MODE_400K: begin
				bus_hz = 400_000; t_low_ns = 650; t_high_ns = 340;
				t_sda_ns = 100; t_scl_ns = 200;
			end
			MODE_50K: begin
				bus_hz = 50_000; t_low_ns = 5200; t_high_ns = 4300;
				t_sda_ns = 350; t_scl_ns = 350;
			end
			default: begin
				bus_hz = 100_000; t_low_ns = 4900; t_high_ns = 4200;
				t_sda_ns = 280; t_scl_ns = 320;
			end
		endcase
		if (hz != 32'd0) begin
			for (p = 0; p < PRESCALE_STEPS && p < 16; p++) begin
				if (!found) begin
					f = longint'(hz) / (p + 1);
					low_min = ns_to_ticks(t_low_ns, f);
					high_min = ns_to_ticks(t_high_ns, f);
					sdadel = ns_to_ticks(t_sda_ns, f);
					scldel = ns_to_ticks(t_scl_ns, f);
					if (low_min < MIN_COUNT) low_min = MIN_COUNT;
					if (high_min < MIN_COUNT) high_min = MIN_COUNT;
					if (sdadel > DELAY_CAP) sdadel = DELAY_CAP;
					if (scldel > DELAY_CAP) scldel = DELAY_CAP;
					period = f / bus_hz;
					if (period >= low_min + high_min + 8) begin
						scll = period - high_min - 6;
						if (scll >= low_min && scll <= COUNT_MAX && high_min <= COUNT_MAX) begin
							r.word = {4'(p), 4'd0, 4'(scldel), 4'(sdadel), 8'(high_min),
								8'(scll)};
							r.fallback = 1'b0;
							found = 1'b1;
						end
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		timing_result_t want;
		if (!arst_n) begin
			expected_words.delete();
			error_count = 0;
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					if (error_count < 10)
						$display("unexpected word: word=%h fallback=%0b", timing_word,
							used_fallback);
					error_count++;
				end else begin
					want = expected_words.pop_front();
					if (want.word !== timing_word || want.fallback !== used_fallback) begin
						if (error_count < 10)
							$display("mismatch hz=%0d mode=%0d: expected word=%h fallback=%0b, got word=%h fallback=%0b",
								want.hz, want.mode, want.word, want.fallback, timing_word,
								used_fallback);
						error_count++;
					end
				end
			end
			if (start && !busy)
				expected_words.push_back(predict_timing_word(kernel_clock_hz, speed_mode));
		end
		words_in_flight = expected_words.size();
	end

endmodule

// File: verif/i2c_timing_word_calculator_top_tb.sv
// testbench top for the i2c timing word calculator: clock, reset, request stimulus
// and verdict; depends on itc_pkg, the block and itc_word_checker
`timescale 1ns / 1ps

module i2c_timing_word_calculator_top_tb;
	import itc_pkg::*;

	localparam int STALL_LIMIT = 25000;
	localparam int TAIL_CYCLES = 6000;
	localparam int PHASE_WORDS = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [31:0] kernel_clock_hz = 32'd0;
	logic [1:0] speed_mode = 2'd0;
	logic busy;
	logic done;
	logic [31:0] timing_word;
	logic used_fallback;
	int error_count;
	int words_in_flight;
	int idle_pct = 0;
	int quiet_cycles = 0;

	i2c_timing_word_calculator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kernel_clock_hz(kernel_clock_hz),
		.speed_mode(speed_mode),
		.done(done),
		.timing_word(timing_word),
		.used_fallback(used_fallback)
	);

	itc_word_checker CHK (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kernel_clock_hz(kernel_clock_hz),
		.speed_mode(speed_mode),
		.done(done),
		.timing_word(timing_word),
		.used_fallback(used_fallback),
		.error_count(error_count),
		.words_in_flight(words_in_flight)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_word(input logic [31:0] hz, input logic [1:0] mode);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kernel_clock_hz <= hz;
		speed_mode <= mode;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_words();
		start <= 1'b0;
		@(negedge clk);
		while (words_in_flight != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [31:0] hz;
		logic [1:0] mode;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero clock and clocks too slow or too fast to fit
		send_word(32'd0, 2'd0);
		send_word(32'd0, 2'd3);
		send_word(32'd1, 2'd0);
		send_word(32'hFFFF_FFFF, 2'd0);
		send_word(32'hFFFF_FFFF, MODE_400K);
		send_word(32'hFFFF_FFFF, MODE_50K);
		send_word(32'hFFFF_FFFF, 2'd3);
		send_word(32'd2_000_000, MODE_400K);
		// typical clocks in every mode
		send_word(32'd8_000_000, 2'd0);
		send_word(32'd16_000_000, 2'd3);
		send_word(32'd16_000_000, MODE_400K);
		send_word(32'd48_000_000, MODE_50K);
		send_word(32'd64_000_000, 2'd0);
		send_word(32'd100_000_000, MODE_400K);
		send_word(32'd120_000_000, MODE_50K);
		send_word(32'd200_000_000, 2'd0);
		send_word(32'd480_000_000, MODE_400K);
		// around the first prescaler that fits
		send_word(32'd10_000_000, 2'd0);
		send_word(32'd11_000_000, 2'd0);
		send_word(32'd12_000_000, 2'd3);
		send_word(32'd1_000_000_000, MODE_400K);
		send_word(32'd2_000_000_000, MODE_50K);

		for (int phase = 0; phase < 4; phase++) begin
			drain_words();
			case (phase)
				1: idle_pct = 77;
				3: idle_pct = 19;
				default: idle_pct = 0;
			endcase
			repeat (PHASE_WORDS) begin
				case ($urandom_range(9))
					0: hz = $urandom;
					1: hz = $urandom_range(3_000_000);
					2, 3, 4, 5: hz = $urandom_range(100_000_000, 4_000_000);
					6, 7: hz = $urandom_range(500_000_000, 100_000_000);
					8: hz = 32'($urandom_range(20)) * 32'd10_000_000;
					default: hz = $urandom_range(1_100_000_000, 500_000_000);
				endcase
				mode = 2'($urandom_range(3));
				send_word(hz, mode);
			end
		end

		drain_words();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/itc_pkg.sv
rtl/itc_sdiv.sv
rtl/i2c_timing_word_calculator_top.sv
rtl/itc_checker.sv
verif/itc_word_checker.sv
verif/i2c_timing_word_calculator_top_tb.sv
